FILE: rtl/ngh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Noise gate package
// Shared widths, register indexes, command types and fixed-point helpers.
// ----------------------------------------------------------------------------
package ngh_pkg;

  localparam int NumLanes    = 4;
  localparam int Channels    = 4;
  localparam int ActiveLanes = (Channels < NumLanes) ? Channels : NumLanes;

  localparam int SampleW  = 24;
  localparam int LevelW   = 23;
  localparam int GainW    = 25;
  localparam int CoeffW   = 17;
  localparam int HoldW    = 20;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;
  localparam int LaneIdxW = $clog2(NumLanes);
  localparam int MulW     = 26;
  localparam int ProdW    = 2 * MulW;
  localparam int SumW     = 37;

  localparam logic [GainW-1:0]  GainUnity = 25'h080_0000;
  localparam logic [LevelW-1:0] LevelMax  = 23'h7F_FFFF;

  localparam logic [CfgIdxW-1:0] RegSidechain = 3'd0;
  localparam logic [CfgIdxW-1:0] RegThreshold = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRange     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOpenCoef  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCloseCoef = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRiseCoef  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFallCoef  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegHold      = 3'd7;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    logic                use_sidechain;
    logic [LevelW-1:0]   threshold_level;
    logic [SampleW-1:0]  range_gain;
    logic [CoeffW-1:0]   open_coeff;
    logic [CoeffW-1:0]   close_coeff;
    logic [CoeffW-1:0]   level_rise_coeff;
    logic [CoeffW-1:0]   level_fall_coeff;
    logic [HoldW-1:0]    hold_samples;
  } cfg_t;

  typedef enum logic [1:0] {
    MulLevel,
    MulGain,
    MulChan
  } mul_sel_e;

  typedef struct packed {
    logic                capture;
    mul_sel_e            mul_sel;
    logic                prod_en;
    logic                lvl_upd;
    logic                gain_upd;
    logic                ch_store;
    logic [LaneIdxW-1:0] ch_idx;
    logic                out_load;
  } dp_cmd_t;

  // Magnitude of a Q1.23 sample; the most negative code saturates.
  function automatic logic [LevelW-1:0] abs_mag(input sample_t x);
    logic [SampleW-1:0] neg;
    neg = -x;
    if (!x[SampleW-1]) begin
      return x[LevelW-1:0];
    end else if (x == {1'b1, {(SampleW-1){1'b0}}}) begin
      return LevelMax;
    end else begin
      return neg[LevelW-1:0];
    end
  endfunction

  function automatic logic [LevelW-1:0] clamp_level(input logic signed [SumW-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({{(SumW-LevelW){1'b0}}, LevelMax})) begin
      return LevelMax;
    end else begin
      return v[LevelW-1:0];
    end
  endfunction

  function automatic logic [GainW-1:0] clamp_gain(input logic signed [SumW-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed({{(SumW-GainW){1'b0}}, GainUnity})) begin
      return GainUnity;
    end else begin
      return v[GainW-1:0];
    end
  endfunction

  function automatic sample_t sat_sample(input logic signed [ProdW-24:0] v);
    if (v < -$signed({{(ProdW-23-GainW){1'b0}}, GainUnity})) begin
      return {1'b1, {(SampleW-1){1'b0}}};
    end else if (v > $signed({{(ProdW-23-LevelW){1'b0}}, LevelMax})) begin
      return {1'b0, {(SampleW-1){1'b1}}};
    end else begin
      return v[SampleW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ngh_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Noise gate configuration registers
// Holds the eight control registers written over the configuration channel.
// ----------------------------------------------------------------------------
module ngh_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [ngh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ngh_pkg::CfgDataW-1:0] cfg_data_i,
  output ngh_pkg::cfg_t                cfg_o
);
  import ngh_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_sidechain    <= 1'b0;
      cfg_q.threshold_level  <= '0;
      cfg_q.range_gain       <= '0;
      cfg_q.open_coeff       <= 17'd65536;
      cfg_q.close_coeff      <= 17'd65536;
      cfg_q.level_rise_coeff <= 17'd22348;
      cfg_q.level_fall_coeff <= 17'd65536;
      cfg_q.hold_samples     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSidechain: cfg_q.use_sidechain    <= cfg_data_i[0];
        RegThreshold: cfg_q.threshold_level  <= cfg_data_i[LevelW-1:0];
        RegRange:     cfg_q.range_gain       <= cfg_data_i[SampleW-1:0];
        RegOpenCoef:  cfg_q.open_coeff       <= cfg_data_i[CoeffW-1:0];
        RegCloseCoef: cfg_q.close_coeff      <= cfg_data_i[CoeffW-1:0];
        RegRiseCoef:  cfg_q.level_rise_coeff <= cfg_data_i[CoeffW-1:0];
        RegFallCoef:  cfg_q.level_fall_coeff <= cfg_data_i[CoeffW-1:0];
        RegHold:      cfg_q.hold_samples     <= cfg_data_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/ngh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Noise gate controller
// Sequences one frame through the shared multiplier and owns the handshakes.
// ----------------------------------------------------------------------------
module ngh_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ngh_pkg::dp_cmd_t cmd_o
);
  import ngh_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StLvlMul  = 3'd1;
  localparam logic [2:0] StLvlUpd  = 3'd2;
  localparam logic [2:0] StGainMul = 3'd3;
  localparam logic [2:0] StGainUpd = 3'd4;
  localparam logic [2:0] StChan    = 3'd5;
  localparam logic [2:0] StDone    = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [LaneIdxW-1:0] ch_cnt_q, ch_cnt_d;
  logic                out_valid_q, out_valid_d;
  dp_cmd_t             cmd;

  always_comb begin
    state_d     = state_q;
    ch_cnt_d    = ch_cnt_q;
    cmd         = '0;
    cmd.mul_sel = MulLevel;
    cmd.ch_idx  = ch_cnt_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = StLvlMul;
        end
      end
      StLvlMul: begin
        cmd.mul_sel = MulLevel;
        cmd.prod_en = 1'b1;
        state_d     = StLvlUpd;
      end
      StLvlUpd: begin
        cmd.lvl_upd = 1'b1;
        state_d     = StGainMul;
      end
      StGainMul: begin
        cmd.mul_sel = MulGain;
        cmd.prod_en = 1'b1;
        state_d     = StGainUpd;
      end
      StGainUpd: begin
        cmd.gain_upd = 1'b1;
        ch_cnt_d     = '0;
        state_d      = StChan;
      end
      StChan: begin
        cmd.mul_sel  = MulChan;
        cmd.ch_store = 1'b1;
        if (ch_cnt_q == LaneIdxW'(NumLanes - 1)) begin
          state_d = StDone;
        end else begin
          ch_cnt_d = ch_cnt_q + 1'b1;
        end
      end
      StDone: begin
        // The finished frame waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ch_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_cnt_q    <= ch_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule
`default_nettype wire

FILE: rtl/ngh_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Noise gate datapath
// Level detector, hold counter, gain smoother and channel gain stage around
// one shared signed multiplier.
// ----------------------------------------------------------------------------
module ngh_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ngh_pkg::cfg_t    cfg_i,
  input  ngh_pkg::dp_cmd_t cmd_i,
  input  ngh_pkg::sample_t sample_i [ngh_pkg::NumLanes],
  input  ngh_pkg::sample_t sidechain_i,
  output ngh_pkg::sample_t gated_o [ngh_pkg::NumLanes],
  output logic             gate_open_o
);
  import ngh_pkg::*;

  sample_t                  s_q [NumLanes];
  sample_t                  res_q [NumLanes];
  sample_t                  gated_q [NumLanes];
  logic                     open_q;
  logic [LevelW-1:0]        level_q;
  logic [LevelW-1:0]        level_d;
  logic signed [ProdW-1:0]  prod_q;
  logic [LevelW-1:0]        det_q;
  logic [HoldW-1:0]         hold_q;
  logic [GainW-1:0]         gain_q;

  logic signed [LevelW+1:0] lvl_diff;
  logic [CoeffW-1:0]        lvl_coeff;
  logic [GainW-1:0]         gain_tgt;
  logic signed [MulW-1:0]   gain_diff;
  logic [CoeffW-1:0]        gain_coeff;
  logic signed [MulW-1:0]   mul_a;
  logic signed [MulW-1:0]   mul_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [SumW-1:0]   step;
  logic signed [SumW-1:0]   lvl_sum;
  logic signed [SumW-1:0]   gain_sum;
  logic [LevelW-1:0]        det_new;
  sample_t                  ch_res;

  // Peak magnitude over the active channels, or the sidechain magnitude.
  always_comb begin
    logic [LevelW-1:0] mag;
    level_d = '0;
    for (int k = 0; k < ActiveLanes; k++) begin
      mag = abs_mag(sample_i[k]);
      if (mag > level_d) begin
        level_d = mag;
      end
    end
    if (cfg_i.use_sidechain) begin
      level_d = abs_mag(sidechain_i);
    end
  end

  assign lvl_diff   = $signed({2'b00, level_q}) - $signed({2'b00, det_q});
  assign lvl_coeff  = (level_q > det_q) ? cfg_i.level_rise_coeff : cfg_i.level_fall_coeff;
  assign gain_tgt   = (hold_q != '0) ? GainUnity : {1'b0, cfg_i.range_gain};
  assign gain_diff  = $signed({1'b0, gain_tgt}) - $signed({1'b0, gain_q});
  assign gain_coeff = (hold_q != '0) ? cfg_i.open_coeff : cfg_i.close_coeff;

  always_comb begin
    case (cmd_i.mul_sel)
      MulLevel: begin
        mul_a = {lvl_diff[LevelW+1], lvl_diff};
        mul_b = $signed({{(MulW-CoeffW){1'b0}}, lvl_coeff});
      end
      MulGain: begin
        mul_a = gain_diff;
        mul_b = $signed({{(MulW-CoeffW){1'b0}}, gain_coeff});
      end
      MulChan: begin
        mul_a = {{(MulW-SampleW){s_q[cmd_i.ch_idx][SampleW-1]}}, s_q[cmd_i.ch_idx]};
        mul_b = $signed({1'b0, gain_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Dropping low product bits of a signed value rounds toward minus infinity.
  assign step     = $signed({prod_q[ProdW-1], prod_q[ProdW-1:16]});
  assign lvl_sum  = $signed({{(SumW-LevelW){1'b0}}, det_q}) + step;
  assign gain_sum = $signed({{(SumW-GainW){1'b0}}, gain_q}) + step;
  assign det_new  = clamp_level(lvl_sum);
  assign ch_res   = sat_sample(prod[ProdW-1:23]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_q  <= '0;
      hold_q <= '0;
      gain_q <= GainUnity;
    end else begin
      if (cmd_i.lvl_upd) begin
        det_q <= det_new;
        if (det_new >= cfg_i.threshold_level) begin
          hold_q <= cfg_i.hold_samples;
        end else if (hold_q != '0) begin
          hold_q <= hold_q - 1'b1;
        end
      end
      if (cmd_i.gain_upd) begin
        gain_q <= clamp_gain(gain_sum);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q     <= sample_i;
      level_q <= level_d;
    end
    if (cmd_i.prod_en) begin
      prod_q <= prod;
    end
    if (cmd_i.ch_store) begin
      res_q[cmd_i.ch_idx] <= (int'(cmd_i.ch_idx) < ActiveLanes) ? ch_res : '0;
    end
    if (cmd_i.out_load) begin
      gated_q <= res_q;
      open_q  <= (hold_q != '0);
    end
  end

  assign gated_o     = gated_q;
  assign gate_open_o = open_q;

endmodule
`default_nettype wire

FILE: rtl/noise_gate_hold_smoothing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Noise gate with hold and gain smoothing
// Multichannel audio gate: peak or sidechain detector, smoothed level, hold
// counter and a gliding gain applied to every channel.
// ----------------------------------------------------------------------------
// Usage:
//   Frames enter on the input channel (four channel samples and a sidechain
//   sample, Q1.23) with in_valid_i/in_ready_o. Each accepted request yields
//   exactly one result on the output channel with out_valid_o/out_ready_i:
//   four gated samples and the gate_open flag.
//   Registers are written on the configuration channel, which is always
//   ready; write them only while no frame is in flight.
//   The frame steps through the level product, level update, gain product,
//   gain update, one product per channel on the single shared multiplier
//   (six products per frame) and a done state that loads the output
//   register. The input reopens only after that, so a frame is finished
//   before the next is taken.
//   A stalled receiver holds the finished result in the output register
//   while the next frame is accepted and processed; that frame then waits
//   until the output register is taken.
//   Reset clears the detector level and hold counter, sets the gain to
//   unity and loads the register defaults.
// ----------------------------------------------------------------------------
module noise_gate_hold_smoothing (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ngh_pkg::sample_t             sample_ch0_i,
  input  ngh_pkg::sample_t             sample_ch1_i,
  input  ngh_pkg::sample_t             sample_ch2_i,
  input  ngh_pkg::sample_t             sample_ch3_i,
  input  ngh_pkg::sample_t             sidechain_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ngh_pkg::sample_t             gated_ch0_o,
  output ngh_pkg::sample_t             gated_ch1_o,
  output ngh_pkg::sample_t             gated_ch2_o,
  output ngh_pkg::sample_t             gated_ch3_o,
  output logic                         gate_open_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ngh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ngh_pkg::CfgDataW-1:0] cfg_data_i
);
  import ngh_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  sample_t samples [NumLanes];
  sample_t gated [NumLanes];

  assign samples[0] = sample_ch0_i;
  assign samples[1] = sample_ch1_i;
  assign samples[2] = sample_ch2_i;
  assign samples[3] = sample_ch3_i;

  assign gated_ch0_o = gated[0];
  assign gated_ch1_o = gated[1];
  assign gated_ch2_o = gated[2];
  assign gated_ch3_o = gated[3];

  assign cfg_ready_o = 1'b1;

  ngh_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ngh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ngh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .sample_i    (samples),
    .sidechain_i (sidechain_sample_i),
    .gated_o     (gated),
    .gate_open_o (gate_open_o)
  );

  // One frame at a time: after a request is taken the input closes.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted again right after a request");

  // A fresh result only appears at the end of a frame's processing.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result presented while the block was idle");

  // The input cannot reopen after a frame while no result was pending unless
  // the new result is shown in the same cycle.
  a_reopen_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_ready_o && !out_valid_o) |=> (!in_ready_o || out_valid_o))
    else $error("frame finished without presenting a result");

endmodule
`default_nettype wire
